[design/ctf_pkg.sv]
// Package for the calibration table fill block: sizes, controller states and
// the command and status words between controller and datapath.
// Depends on nothing; every other file of the block but ctf_ram uses it.
package ctf_pkg;

   localparam int ENTRIES       = 32;
   localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W         = $clog2(ENTRIES + 1);
   localparam int DATA_W        = 16;
   localparam int INDEX_FIELD_W = 5;
   localparam int WORD_W        = 2 * DATA_W + 1;
   localparam int PROD_W        = DATA_W + IDX_W;
   localparam int NUM_W         = PROD_W + 2;
   localparam int DEN_W         = IDX_W + 1;
   localparam int STEP_W        = $clog2(NUM_W + 1);
   localparam int OFS_W         = DATA_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_FIND_CHECK,
      ST_ENTRY_READ,
      ST_ENTRY_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT
   } ctf_state_type;

   typedef struct packed {
      logic load;
      logic begin_fill;
      logic scan_read;
      logic scan_step;
      logic set_none;
      logic entry_read;
      logic emit_pass;
      logic emit_offset;
      logic mul;
      logic div_start;
      logic emit_interp;
   } ctf_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic mark;
      logic both;
      logic last_entry;
      logic div_done;
   } ctf_status_type;

   // Low bits of a table position as carried on the result index field.
   function automatic logic [INDEX_FIELD_W-1:0] index_field(input logic [IDX_W-1:0] idx);
      logic [IDX_W+INDEX_FIELD_W-1:0] wide;
      wide = {{INDEX_FIELD_W{1'b0}}, idx};
      return wide[INDEX_FIELD_W-1:0];
   endfunction

endpackage

[design/calibration_table_fill.sv]
// Calibration table fill: loads table entries one word at a time and, after
// the last one, emits the filled table in index order.
// Load side: a word (value, user-set mark, default, last flag) is taken at a
// rising edge with start high and busy low; one word is taken per cycle.
// Words beyond the table depth are dropped, but a last flag still starts the
// fill. The word carrying the last flag raises busy until the whole table has
// been emitted.
// Result side: each result word is shown for exactly one cycle with rsp_strobe
// high; the receiver cannot stall, so nothing is ever held back. The final
// word carries rsp_last_result, and busy falls in that same cycle.
// Fill sequence, per entry: an unset entry with at most one user-set neighbour
// is read and then emitted; a user-set entry is read and emitted, and unless it
// is the final entry the search for the next user-set neighbour then reads and
// checks each entry scanned and notes when none is left. The fill opens with
// the same search. An interpolated entry is read, its products are formed, and
// the bit-serial divider is started and waited on. The single read port of the
// entry store serialises the search and the entry reads.
// Reset (synchronous) empties the load count and abandons any fill; store
// contents are not cleared and need no clearing pass.
module calibration_table_fill (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ctf_pkg::DATA_W-1:0]           req_entry_value,
   input  logic                                 req_user_set,
   input  logic [ctf_pkg::DATA_W-1:0]           req_default_value,
   input  logic                                 req_last_loaded,
   output logic                                 rsp_strobe,
   output logic [ctf_pkg::INDEX_FIELD_W-1:0]    rsp_entry_index,
   output logic [ctf_pkg::DATA_W-1:0]           rsp_filled_value,
   output logic                                 rsp_clamped,
   output logic                                 rsp_last_result
);

   ctf_pkg::ctf_cmd_type    cmd;
   ctf_pkg::ctf_status_type status;
   logic                    ctrl_busy;

   ctf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_last_loaded (req_last_loaded),
      .status          (status),
      .cmd             (cmd),
      .busy            (ctrl_busy)
   );

   ctf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_entry_value   (req_entry_value),
      .req_user_set      (req_user_set),
      .req_default_value (req_default_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_filled_value  (rsp_filled_value),
      .rsp_clamped       (rsp_clamped),
      .rsp_last_result   (rsp_last_result)
   );

   assign busy = ctrl_busy;

`ifndef SYNTHESIS
   // Results only come out of a fill that was running in the cycle before.
   a_strobe_in_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word outside a fill");

   // A result that is not the final one leaves the fill running.
   a_fill_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_result) |-> busy)
      else $error("fill ended before its final word");

   // A fill ends only together with its final result word.
   a_fill_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_strobe && rsp_last_result))
      else $error("fill ended without a final word");
`endif

endmodule

[design/ctf_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ctf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ctf_div.sv]
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on ctf_pkg.
module ctf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ctf_pkg::NUM_W-1:0]    num,
   input  logic [ctf_pkg::DEN_W-1:0]    dvs,
   output logic                         done,
   output logic [ctf_pkg::NUM_W-1:0]    quot
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [ctf_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [ctf_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [ctf_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [ctf_pkg::DEN_W-1:0]     dvs_ff, dvs_in;
   logic [ctf_pkg::DEN_W:0]       rem_sh;
   logic [ctf_pkg::DEN_W:0]       diff;
   logic                          ge;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[ctf_pkg::NUM_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      if (start) begin
         run_in  = 1'b1;
         step_in = ctf_pkg::STEP_W'(ctf_pkg::NUM_W);
         rem_in  = '0;
         quo_in  = num;
         dvs_in  = dvs;
      end else if (run_ff) begin
         rem_in  = ge ? diff[ctf_pkg::DEN_W-1:0] : rem_sh[ctf_pkg::DEN_W-1:0];
         quo_in  = {quo_ff[ctf_pkg::NUM_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == ctf_pkg::STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[design/ctf_datapath.sv]
// Datapath of the calibration table fill: entry store, neighbour registers,
// products, divider and result registers. Depends on ctf_pkg, ctf_ram, ctf_div.
module ctf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ctf_pkg::ctf_cmd_type                 cmd,
   output ctf_pkg::ctf_status_type              status,
   input  logic [ctf_pkg::DATA_W-1:0]           req_entry_value,
   input  logic                                 req_user_set,
   input  logic [ctf_pkg::DATA_W-1:0]           req_default_value,
   output logic                                 rsp_strobe,
   output logic [ctf_pkg::INDEX_FIELD_W-1:0]    rsp_entry_index,
   output logic [ctf_pkg::DATA_W-1:0]           rsp_filled_value,
   output logic                                 rsp_clamped,
   output logic                                 rsp_last_result
);

   localparam int DW = ctf_pkg::DATA_W;
   localparam int IW = ctf_pkg::IDX_W;
   localparam int CW = ctf_pkg::CNT_W;
   localparam int PW = ctf_pkg::PROD_W;
   localparam int OW = ctf_pkg::OFS_W;

   logic [CW-1:0] load_count_ff, load_count_in;
   logic [CW-1:0] fill_count_ff, fill_count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic          p_valid_ff, p_valid_in;
   logic [IW-1:0] p_idx_ff, p_idx_in;
   logic [DW-1:0] p_value_ff, p_value_in;
   logic [DW-1:0] p_default_ff, p_default_in;
   logic          n_valid_ff, n_valid_in;
   logic [IW-1:0] n_idx_ff, n_idx_in;
   logic [DW-1:0] n_value_ff, n_value_in;
   logic [DW-1:0] n_default_ff, n_default_in;
   logic [PW-1:0] prod_a_ff, prod_a_in;
   logic [PW-1:0] prod_b_ff, prod_b_in;

   logic                              strobe_ff, strobe_in;
   logic [ctf_pkg::INDEX_FIELD_W-1:0] index_ff, index_in;
   logic [DW-1:0]                     value_ff, value_in;
   logic                              clamped_ff, clamped_in;
   logic                              last_ff, last_in;

   logic                          full;
   logic [CW-1:0]                 count_next;
   logic                          wr_en;
   logic                          rd_en;
   logic [IW-1:0]                 rd_addr;
   logic [ctf_pkg::WORD_W-1:0]    wr_word;
   logic [ctf_pkg::WORD_W-1:0]    rd_word;
   logic                          rd_mark;
   logic [DW-1:0]                 rd_value;
   logic [DW-1:0]                 rd_default;
   logic [IW-1:0]                 den;
   logic [PW:0]                   prod_sum;
   logic [ctf_pkg::NUM_W-1:0]     div_num;
   logic [ctf_pkg::DEN_W-1:0]     div_dvs;
   logic                          div_done;
   logic [ctf_pkg::NUM_W-1:0]     div_quot;
   logic [DW-1:0]                 nb_value;
   logic [DW-1:0]                 nb_default;
   logic [OW-1:0]                 offset_sum;

   assign full       = (load_count_ff >= CW'(ctf_pkg::ENTRIES));
   assign count_next = full ? load_count_ff : load_count_ff + 1'b1;
   assign wr_en      = cmd.load && !full;
   assign wr_word    = {req_user_set, req_entry_value, req_default_value};
   assign rd_en      = cmd.scan_read || cmd.entry_read;
   assign rd_addr    = cmd.scan_read ? scan_ff[IW-1:0] : pos_ff;

   ctf_ram #(
      .WIDTH(ctf_pkg::WORD_W),
      .DEPTH(ctf_pkg::ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_count_ff[IW-1:0]),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_mark    = rd_word[ctf_pkg::WORD_W-1];
   assign rd_value   = rd_word[2*DW-1:DW];
   assign rd_default = rd_word[DW-1:0];

   // Numerator 2T + den and divisor 2*den give the half-away rounding.
   assign den      = n_idx_ff - p_idx_ff;
   assign prod_sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
   assign div_num  = ctf_pkg::NUM_W'({prod_sum, 1'b0}) + ctf_pkg::NUM_W'(den);
   assign div_dvs  = {den, 1'b0};

   ctf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .dvs   (div_dvs),
      .done  (div_done),
      .quot  (div_quot)
   );

   // With a neighbour on one side only, its offset from default is copied.
   assign nb_value   = p_valid_ff ? p_value_ff : n_value_ff;
   assign nb_default = p_valid_ff ? p_default_ff : n_default_ff;
   assign offset_sum = {2'b00, rd_default} - {2'b00, nb_default} + {2'b00, nb_value};

   always_comb begin
      load_count_in = load_count_ff;
      fill_count_in = fill_count_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      p_valid_in    = p_valid_ff;
      p_idx_in      = p_idx_ff;
      p_value_in    = p_value_ff;
      p_default_in  = p_default_ff;
      n_valid_in    = n_valid_ff;
      n_idx_in      = n_idx_ff;
      n_value_in    = n_value_ff;
      n_default_in  = n_default_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      strobe_in     = 1'b0;
      index_in      = index_ff;
      value_in      = value_ff;
      clamped_in    = clamped_ff;
      last_in       = last_ff;

      if (cmd.load) begin
         load_count_in = cmd.begin_fill ? '0 : count_next;
      end
      if (cmd.begin_fill) begin
         fill_count_in = count_next;
         scan_in       = '0;
         pos_in        = '0;
         p_valid_in    = 1'b0;
         n_valid_in    = 1'b0;
      end
      if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
         if (rd_mark) begin
            n_valid_in   = 1'b1;
            n_idx_in     = scan_ff[IW-1:0];
            n_value_in   = rd_value;
            n_default_in = rd_default;
         end
      end
      if (cmd.set_none) begin
         n_valid_in = 1'b0;
      end
      if (cmd.mul) begin
         prod_a_in = PW'(p_value_ff) * PW'(n_idx_ff - pos_ff);
         prod_b_in = PW'(n_value_ff) * PW'(pos_ff - p_idx_ff);
      end
      if (cmd.emit_pass || cmd.emit_offset || cmd.emit_interp) begin
         strobe_in  = 1'b1;
         index_in   = ctf_pkg::index_field(pos_ff);
         last_in    = status.last_entry;
         clamped_in = 1'b0;
         pos_in     = pos_ff + 1'b1;
      end
      if (cmd.emit_pass) begin
         value_in     = rd_value;
         p_valid_in   = 1'b1;
         p_idx_in     = pos_ff;
         p_value_in   = rd_value;
         p_default_in = rd_default;
      end
      if (cmd.emit_offset) begin
         if (!p_valid_ff && !n_valid_ff) begin
            value_in = rd_default;
         end else if (offset_sum[OW-1]) begin
            value_in   = '0;
            clamped_in = 1'b1;
         end else if (offset_sum[OW-2]) begin
            value_in   = '1;
            clamped_in = 1'b1;
         end else begin
            value_in = offset_sum[DW-1:0];
         end
      end
      if (cmd.emit_interp) begin
         value_in = div_quot[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         fill_count_ff <= '0;
         scan_ff       <= '0;
         pos_ff        <= '0;
         p_valid_ff    <= 1'b0;
         n_valid_ff    <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         fill_count_ff <= fill_count_in;
         scan_ff       <= scan_in;
         pos_ff        <= pos_in;
         p_valid_ff    <= p_valid_in;
         n_valid_ff    <= n_valid_in;
         strobe_ff     <= strobe_in;
      end
      p_idx_ff     <= p_idx_in;
      p_value_ff   <= p_value_in;
      p_default_ff <= p_default_in;
      n_idx_ff     <= n_idx_in;
      n_value_ff   <= n_value_in;
      n_default_ff <= n_default_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      index_ff     <= index_in;
      value_ff     <= value_in;
      clamped_ff   <= clamped_in;
      last_ff      <= last_in;
   end

   assign status.scan_end   = (scan_ff == fill_count_ff);
   assign status.mark       = rd_mark;
   assign status.both       = p_valid_ff && n_valid_ff;
   assign status.last_entry = (CW'(pos_ff) == fill_count_ff - 1'b1);
   assign status.div_done   = div_done;

   assign rsp_strobe       = strobe_ff;
   assign rsp_entry_index  = index_ff;
   assign rsp_filled_value = value_ff;
   assign rsp_clamped      = clamped_ff;
   assign rsp_last_result  = last_ff;

endmodule

[design/ctf_ctrl.sv]
// Controller of the calibration table fill: sequences loading, the neighbour
// search, the per-entry fill and the divider. Depends on ctf_pkg.
module ctf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_last_loaded,
   input  ctf_pkg::ctf_status_type  status,
   output ctf_pkg::ctf_cmd_type     cmd,
   output logic                     busy
);

   ctf_pkg::ctf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ctf_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last_loaded) begin
                  cmd.begin_fill = 1'b1;
                  state_in       = ctf_pkg::ST_FIND;
               end
            end
         end
         ctf_pkg::ST_FIND: begin
            if (status.scan_end) begin
               cmd.set_none = 1'b1;
               state_in     = ctf_pkg::ST_ENTRY_READ;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = ctf_pkg::ST_FIND_CHECK;
            end
         end
         ctf_pkg::ST_FIND_CHECK: begin
            cmd.scan_step = 1'b1;
            state_in      = status.mark ? ctf_pkg::ST_ENTRY_READ : ctf_pkg::ST_FIND;
         end
         ctf_pkg::ST_ENTRY_READ: begin
            cmd.entry_read = 1'b1;
            state_in       = ctf_pkg::ST_ENTRY_CHECK;
         end
         ctf_pkg::ST_ENTRY_CHECK: begin
            if (status.mark) begin
               // A user-set entry becomes the lower neighbour; search for the next one.
               cmd.emit_pass = 1'b1;
               state_in      = status.last_entry ? ctf_pkg::ST_IDLE : ctf_pkg::ST_FIND;
            end else if (status.both) begin
               cmd.mul  = 1'b1;
               state_in = ctf_pkg::ST_DIV_START;
            end else begin
               cmd.emit_offset = 1'b1;
               state_in = status.last_entry ? ctf_pkg::ST_IDLE : ctf_pkg::ST_ENTRY_READ;
            end
         end
         ctf_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ctf_pkg::ST_DIV_WAIT;
         end
         ctf_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.emit_interp = 1'b1;
               state_in = status.last_entry ? ctf_pkg::ST_IDLE : ctf_pkg::ST_ENTRY_READ;
            end
         end
         default: begin
            state_in = ctf_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ctf_pkg::ST_IDLE);

endmodule
